### sv/dpfd_pkg.sv
// shared types, constants and register codes for the pulse frame decoder
`default_nettype none

package dpfd_pkg;

  localparam int TIME_WIDTH   = 16;
  localparam int CaptureW     = 16;
  localparam int TimeW        = (TIME_WIDTH < CaptureW) ? TIME_WIDTH : CaptureW;
  localparam int ThrW         = 16;
  localparam int LimW         = 8;
  localparam int FrameBits    = 40;
  localparam int CountW       = $clog2(FrameBits + 2);
  localparam int ByteW        = 8;
  localparam int AlarmW       = 3;
  localparam int ApbAddrW     = 5;
  localparam int ApbDataW     = 32;
  localparam int OutDataW     = 48;

  localparam logic [ThrW-1:0] ThrReset    = 16'd100;
  localparam logic [LimW-1:0] TempLoReset = 8'd16;
  localparam logic [LimW-1:0] TempHiReset = 8'd30;
  localparam logic [LimW-1:0] HumLoReset  = 8'd30;
  localparam logic [LimW-1:0] HumHiReset  = 8'd50;

  typedef enum logic [2:0] {
    RegThr    = 3'd0,
    RegTempLo = 3'd1,
    RegTempHi = 3'd2,
    RegHumLo  = 3'd3,
    RegHumHi  = 3'd4
  } cfg_reg_e;

  typedef enum logic [AlarmW-1:0] {
    AlarmNone    = 3'd0,
    AlarmCold    = 3'd1,
    AlarmHot     = 3'd2,
    AlarmHumLow  = 3'd3,
    AlarmHumHigh = 3'd4
  } alarm_e;

  typedef struct packed {
    logic [ThrW-1:0] thr;
    logic [LimW-1:0] temp_lo;
    logic [LimW-1:0] temp_hi;
    logic [LimW-1:0] hum_lo;
    logic [LimW-1:0] hum_hi;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [FrameBits-1:0] bits;
  } frame_t;

  typedef struct packed {
    logic [AlarmW-1:0] alarm_code;
    logic              data_ok;
    logic [ByteW-1:0]  checksum_rx;
    logic [ByteW-1:0]  temp_dec;
    logic [ByteW-1:0]  temp_int;
    logic [ByteW-1:0]  hum_dec;
    logic [ByteW-1:0]  hum_int;
  } res_t;

endpackage

`default_nettype wire

### sv/dpfd_cfg.sv
// apb configuration registers
`default_nettype none

module dpfd_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dpfd_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [dpfd_pkg::ApbDataW-1:0] pwdata,
  output logic      [dpfd_pkg::ApbDataW-1:0] prdata,
  output logic                               pready,
  output dpfd_pkg::cfg_t                     cfg_o
);

  dpfd_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        dpfd_pkg::RegThr:    cfg_d.thr     = pwdata[dpfd_pkg::ThrW-1:0];
        dpfd_pkg::RegTempLo: cfg_d.temp_lo = pwdata[dpfd_pkg::LimW-1:0];
        dpfd_pkg::RegTempHi: cfg_d.temp_hi = pwdata[dpfd_pkg::LimW-1:0];
        dpfd_pkg::RegHumLo:  cfg_d.hum_lo  = pwdata[dpfd_pkg::LimW-1:0];
        dpfd_pkg::RegHumHi:  cfg_d.hum_hi  = pwdata[dpfd_pkg::LimW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dpfd_pkg::RegThr:    prdata = dpfd_pkg::ApbDataW'(cfg_q.thr);
      dpfd_pkg::RegTempLo: prdata = dpfd_pkg::ApbDataW'(cfg_q.temp_lo);
      dpfd_pkg::RegTempHi: prdata = dpfd_pkg::ApbDataW'(cfg_q.temp_hi);
      dpfd_pkg::RegHumLo:  prdata = dpfd_pkg::ApbDataW'(cfg_q.hum_lo);
      dpfd_pkg::RegHumHi:  prdata = dpfd_pkg::ApbDataW'(cfg_q.hum_hi);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr     <= dpfd_pkg::ThrReset;
      cfg_q.temp_lo <= dpfd_pkg::TempLoReset;
      cfg_q.temp_hi <= dpfd_pkg::TempHiReset;
      cfg_q.hum_lo  <= dpfd_pkg::HumLoReset;
      cfg_q.hum_hi  <= dpfd_pkg::HumHiReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### sv/dpfd_edge.sv
// edge period measurement, bit shift register and frame counter
`default_nettype none

module dpfd_edge (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [dpfd_pkg::CaptureW-1:0] capture_time_i,
  input  wire logic                          frame_start_i,
  input  wire logic [dpfd_pkg::ThrW-1:0]     thr_i,
  output dpfd_pkg::frame_t                   frame_o
);

  logic [dpfd_pkg::TimeW-1:0]     prev_q, prev_d, now;
  logic [dpfd_pkg::CountW-1:0]    count_q, count_d;
  logic [dpfd_pkg::FrameBits-1:0] bits_q, bits_d, bits_next;
  logic [dpfd_pkg::FrameBits-1:0] frame_bits_q, frame_bits_d;
  logic                           frame_vld_q, frame_vld_d;
  logic [dpfd_pkg::TimeW-1:0]     period;
  logic [dpfd_pkg::ThrW-1:0]      period_ext;
  logic                           bit_val;
  logic                           ref_edge;

  assign now        = capture_time_i[dpfd_pkg::TimeW-1:0];
  assign period     = now - prev_q;
  assign period_ext = dpfd_pkg::ThrW'(period);
  assign bit_val    = (period_ext >= thr_i);
  assign bits_next  = {bits_q[dpfd_pkg::FrameBits-2:0], bit_val};
  assign ref_edge   = frame_start_i | (count_q == '0);

  always_comb begin
    prev_d       = prev_q;
    count_d      = count_q;
    bits_d       = bits_q;
    frame_bits_d = frame_bits_q;
    frame_vld_d  = 1'b0;
    if (accept_i) begin
      prev_d = now;
      if (ref_edge) begin
        count_d = dpfd_pkg::CountW'(1);
        bits_d  = '0;
      end else if (count_q == dpfd_pkg::CountW'(dpfd_pkg::FrameBits)) begin
        // last bit of the frame
        count_d      = '0;
        bits_d       = bits_next;
        frame_bits_d = bits_next;
        frame_vld_d  = 1'b1;
      end else begin
        count_d = count_q + dpfd_pkg::CountW'(1);
        bits_d  = bits_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      count_q     <= '0;
      bits_q      <= '0;
      frame_vld_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      count_q     <= count_d;
      bits_q      <= bits_d;
      frame_vld_q <= frame_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_bits_q <= frame_bits_d;
  end

  assign frame_o.valid = frame_vld_q;
  assign frame_o.bits  = frame_bits_q;

endmodule

`default_nettype wire

### sv/dpfd_out.sv
// checksum and alarm evaluation with output register and skid stage
`default_nettype none

module dpfd_out (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dpfd_pkg::frame_t frame_i,
  input  wire dpfd_pkg::cfg_t   cfg_i,
  input  wire logic             ready_i,
  output logic                  valid_o,
  output logic                  full_o,
  output dpfd_pkg::res_t        res_o
);

  dpfd_pkg::res_t             res_new;
  dpfd_pkg::res_t             main_q, main_d, skid_q, skid_d;
  logic                       main_vld_q, main_vld_d, skid_vld_q, skid_vld_d;
  logic [dpfd_pkg::ByteW-1:0] sum;
  logic                       push, pop;

  always_comb begin
    res_new.hum_int     = frame_i.bits[39:32];
    res_new.hum_dec     = frame_i.bits[31:24];
    res_new.temp_int    = frame_i.bits[23:16];
    res_new.temp_dec    = frame_i.bits[15:8];
    res_new.checksum_rx = frame_i.bits[7:0];
    sum = res_new.hum_int + res_new.hum_dec + res_new.temp_int + res_new.temp_dec;
    res_new.data_ok = (sum == res_new.checksum_rx);
    if (res_new.temp_int < cfg_i.temp_lo) begin
      res_new.alarm_code = dpfd_pkg::AlarmCold;
    end else if (res_new.temp_int > cfg_i.temp_hi) begin
      res_new.alarm_code = dpfd_pkg::AlarmHot;
    end else if (res_new.hum_int < cfg_i.hum_lo) begin
      res_new.alarm_code = dpfd_pkg::AlarmHumLow;
    end else if (res_new.hum_int > cfg_i.hum_hi) begin
      res_new.alarm_code = dpfd_pkg::AlarmHumHigh;
    end else begin
      res_new.alarm_code = dpfd_pkg::AlarmNone;
    end
  end

  assign push = frame_i.valid;
  assign pop  = main_vld_q & ready_i;

  always_comb begin
    main_d     = main_q;
    skid_d     = skid_q;
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    if (!main_vld_q || pop) begin
      if (skid_vld_q) begin
        main_d     = skid_q;
        main_vld_d = 1'b1;
        skid_d     = res_new;
        skid_vld_d = push;
      end else begin
        main_d     = res_new;
        main_vld_d = push;
      end
    end else if (push) begin
      skid_d     = res_new;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign valid_o = main_vld_q;
  assign full_o  = skid_vld_q;
  assign res_o   = main_q;

endmodule

`default_nettype wire

### sv/dht_pulse_frame_decoder.sv
// top level of the single-wire humidity and temperature frame decoder
//
// One captured timer value per sensor line edge enters per clock cycle while
// s_axis_tready is high. The first edge of a frame is a reference edge; each
// of the next FrameBits edges gives one bit, set when the wrapped period to
// the previous edge reaches the threshold register. After the last bit edge,
// the result passes the registered edge counter and shift register, then the
// checksum and alarm stage, to the master side. Output register and skid
// stage hold two results, so s_axis_tready falls only while two results wait
// to be taken. Reset clears valid flags and counters, presets config regs.
`default_nettype none

module dht_pulse_frame_decoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // capture_time [15:0]
  input  wire logic [dpfd_pkg::CaptureW-1:0] s_axis_tdata,
  // frame_start [0]
  input  wire logic                          s_axis_tuser,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // hum_int [7:0], hum_dec [15:8], temp_int [23:16], temp_dec [31:24],
  // checksum_rx [39:32], alarm_code [42:40], zero [47:43]
  output logic [dpfd_pkg::OutDataW-1:0]      m_axis_tdata,
  // data_ok [0]
  output logic                               m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dpfd_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [dpfd_pkg::ApbDataW-1:0] pwdata,
  output logic      [dpfd_pkg::ApbDataW-1:0] prdata,
  output logic                               pready
);

  dpfd_pkg::cfg_t   cfg;
  dpfd_pkg::frame_t frame;
  dpfd_pkg::res_t   res;
  logic             out_full;
  logic             accept;

  assign s_axis_tready = ~out_full;
  assign accept        = s_axis_tvalid & s_axis_tready;

  dpfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dpfd_edge u_edge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .capture_time_i (s_axis_tdata),
    .frame_start_i  (s_axis_tuser),
    .thr_i          (cfg.thr),
    .frame_o        (frame)
  );

  dpfd_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame),
    .cfg_i   (cfg),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .full_o  (out_full),
    .res_o   (res)
  );

  assign m_axis_tdata = {5'b0, res.alarm_code, res.checksum_rx, res.temp_dec,
                         res.temp_int, res.hum_dec, res.hum_int};
  assign m_axis_tuser = res.data_ok;

endmodule

`default_nettype wire

### sv/dpfd_checker.sv
// port-level checks for the frame decoder and their bind
`default_nettype none

module dpfd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [dpfd_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic                          m_axis_tuser,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready
);

  logic [dpfd_pkg::ByteW-1:0] sum;

  assign sum = m_axis_tdata[7:0] + m_axis_tdata[15:8] + m_axis_tdata[23:16]
             + m_axis_tdata[31:24];

  // stalled result transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // checksum flag matches the bytes shown
  a_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == (sum == m_axis_tdata[39:32]))
    else $error("data_ok does not match checksum");

  // alarm code stays in its range
  a_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[42:40] <= 3'd4)
    else $error("alarm code out of range");

  // a fresh result follows an earlier accepted input transaction
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a preceding input transaction");

endmodule

bind dht_pulse_frame_decoder dpfd_checker u_dpfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

### tb/sv/testbench.sv
// self-checking testbench for the single-wire humidity and temperature frame decoder
`default_nettype none

module testbench;
  import dpfd_pkg::*;

  typedef struct packed {
    logic [39:0] payload;
    logic [15:0] base;
    logic        lead_start;
    logic [5:0]  nbits;
    logic        typed;
    logic        data_ok;
    alarm_e      alarm;
  } frame_row_t;

  localparam int unsigned NumRegs      = 5;
  localparam int unsigned Phases       = 8;
  localparam int unsigned PhaseEdges   = 100;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned HoldFrames   = 3;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned GapPct [Phases]   = '{0, 65, 0, 22, 0, 65, 0, 22};
  localparam int unsigned StallPct [Phases] = '{0, 0, 65, 22, 0, 0, 65, 22};

  // payload bytes from first to last: hum_int, hum_dec, temp_int, temp_dec, checksum
  localparam frame_row_t FrameRows [14] = '{
    '{40'h00_00_00_00_00, 16'h0000, 1'b1, 6'd40, 1'b1, 1'b1, AlarmCold},
    '{40'hFF_FF_FF_FF_FF, 16'hFFF0, 1'b1, 6'd40, 1'b1, 1'b0, AlarmHot},
    // idle line, first edge without frame start
    '{40'h28_05_16_03_46, 16'h1234, 1'b0, 6'd40, 1'b1, 1'b1, AlarmNone},
    '{40'hA5_5A_C3_3C_99, 16'h8000, 1'b1, 6'd17, 1'b0, 1'b0, AlarmNone},
    // frame start in the middle of a frame
    '{40'h14_00_19_00_2D, 16'h7FFF, 1'b1, 6'd40, 1'b1, 1'b1, AlarmHumLow},
    '{40'h0F_F0_0F_F0_0F, 16'hFF00, 1'b1, 6'd39, 1'b0, 1'b0, AlarmNone},
    // restart on what would be the last edge
    '{40'h3C_00_14_00_00, 16'h0001, 1'b1, 6'd40, 1'b1, 1'b0, AlarmHumHigh},
    '{40'h1E_00_10_00_2E, 16'hFFFF, 1'b1, 6'd40, 1'b1, 1'b1, AlarmNone},
    '{40'h32_00_1E_00_50, 16'h4000, 1'b1, 6'd40, 1'b1, 1'b1, AlarmNone},
    '{40'h3C_00_0F_00_4B, 16'hC000, 1'b1, 6'd40, 1'b1, 1'b1, AlarmCold},
    '{40'h0A_00_1F_00_29, 16'h5555, 1'b1, 6'd40, 1'b1, 1'b1, AlarmHot},
    '{40'h1D_00_10_00_2D, 16'hAAAA, 1'b1, 6'd40, 1'b1, 1'b1, AlarmHumLow},
    '{40'h33_00_1E_00_51, 16'hF00F, 1'b1, 6'd40, 1'b1, 1'b1, AlarmHumHigh},
    '{40'h12_34_56_78_14, 16'h0FF0, 1'b1, 6'd40, 1'b0, 1'b0, AlarmNone}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic [CaptureW-1:0] s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int unsigned cycles      = 0;
  int unsigned hold_until  = 0;
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned errors      = 0;
  int unsigned edges_sent  = 0;

  cfg_t                 cfg_shadow = '{ThrReset, TempLoReset, TempHiReset, HumLoReset, HumHiReset};
  logic [TimeW-1:0]     last_stamp = '0;
  int unsigned          edges_in_frame = 0;
  logic [FrameBits-1:0] shift_bits = '0;
  res_t                 pending_frames [$];

  dht_pulse_frame_decoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (cycles >= hold_until) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic bit decode_edge(input logic [CaptureW-1:0] stamp, input bit restart,
                                     output res_t res);
    logic [TimeW-1:0] period;
    logic [ByteW-1:0] sum;
    res = '0;
    if (restart || edges_in_frame == 0) begin
      last_stamp     = stamp[TimeW-1:0];
      edges_in_frame = 1;
      shift_bits     = '0;
      return 1'b0;
    end
    period         = stamp[TimeW-1:0] - last_stamp;
    shift_bits     = {shift_bits[FrameBits-2:0], period >= cfg_shadow.thr};
    last_stamp     = stamp[TimeW-1:0];
    edges_in_frame = edges_in_frame + 1;
    if (edges_in_frame < FrameBits + 1) return 1'b0;
    res.hum_int     = shift_bits[39:32];
    res.hum_dec     = shift_bits[31:24];
    res.temp_int    = shift_bits[23:16];
    res.temp_dec    = shift_bits[15:8];
    res.checksum_rx = shift_bits[7:0];
    sum             = res.hum_int + res.hum_dec + res.temp_int + res.temp_dec;
    res.data_ok     = (sum == res.checksum_rx);
    if (res.temp_int < cfg_shadow.temp_lo) res.alarm_code = AlarmCold;
    else if (res.temp_int > cfg_shadow.temp_hi) res.alarm_code = AlarmHot;
    else if (res.hum_int < cfg_shadow.hum_lo) res.alarm_code = AlarmHumLow;
    else if (res.hum_int > cfg_shadow.hum_hi) res.alarm_code = AlarmHumHigh;
    else res.alarm_code = AlarmNone;
    edges_in_frame = 0;
    return 1'b1;
  endfunction

  function automatic logic [TimeW-1:0] pick_period(input bit one);
    int unsigned thr;
    thr = cfg_shadow.thr;
    if (one || thr == 0) begin
      return ($urandom_range(0, 3) == 0) ? TimeW'(thr) : TimeW'($urandom_range(thr, 65535));
    end
    return ($urandom_range(0, 3) == 0) ? TimeW'(thr - 1) : TimeW'($urandom_range(0, thr - 1));
  endfunction

  function automatic logic [ByteW-1:0] near_limit(input logic [ByteW-1:0] lim);
    if ($urandom_range(0, 3) == 0) return ByteW'($urandom);
    return ByteW'(lim + $urandom_range(0, 2) - 1);
  endfunction

  function automatic logic [FrameBits-1:0] make_payload();
    logic [ByteW-1:0] hum, hum_d, temp, temp_d, ck;
    hum    = near_limit($urandom_range(0, 1) ? cfg_shadow.hum_lo : cfg_shadow.hum_hi);
    temp   = near_limit($urandom_range(0, 1) ? cfg_shadow.temp_lo : cfg_shadow.temp_hi);
    hum_d  = ByteW'($urandom);
    temp_d = ByteW'($urandom);
    ck     = hum + hum_d + temp + temp_d;
    if ($urandom_range(0, 3) == 0) ck = ByteW'($urandom);
    return {hum, hum_d, temp, temp_d, ck};
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected result transaction: tdata %h, tuser %b", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        check_field("hum_int", want.hum_int, m_axis_tdata[7:0]);
        check_field("hum_dec", want.hum_dec, m_axis_tdata[15:8]);
        check_field("temp_int", want.temp_int, m_axis_tdata[23:16]);
        check_field("temp_dec", want.temp_dec, m_axis_tdata[31:24]);
        check_field("checksum_rx", want.checksum_rx, m_axis_tdata[39:32]);
        check_field("alarm_code", want.alarm_code, m_axis_tdata[42:40]);
        check_field("data_ok", want.data_ok, m_axis_tuser);
      end
    end
  end

  task automatic cfg_write(input int unsigned index, input logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(index * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (index)
      RegThr:    cfg_shadow.thr     = value[ThrW-1:0];
      RegTempLo: cfg_shadow.temp_lo = value[LimW-1:0];
      RegTempHi: cfg_shadow.temp_hi = value[LimW-1:0];
      RegHumLo:  cfg_shadow.hum_lo  = value[LimW-1:0];
      RegHumHi:  cfg_shadow.hum_hi  = value[LimW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_edge(input logic [CaptureW-1:0] stamp, input bit restart,
                           input bit typed, input res_t typed_res);
    res_t res;
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= stamp;
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    edges_sent++;
    if (decode_edge(stamp, restart, res)) pending_frames.push_back(typed ? typed_res : res);
  endtask

  task automatic send_frame(input logic [FrameBits-1:0] payload, input logic [CaptureW-1:0] base,
                            input bit lead, input int nbits, input bit typed, input bit ok,
                            input alarm_e alarm);
    logic [CaptureW-1:0] stamp;
    res_t                typed_res;
    int                  b;
    typed_res = '{alarm_code: alarm, data_ok: ok, checksum_rx: payload[7:0],
                  temp_dec: payload[15:8], temp_int: payload[23:16],
                  hum_dec: payload[31:24], hum_int: payload[39:32]};
    stamp = base;
    send_edge(stamp, lead, typed, typed_res);
    for (b = FrameBits - 1; b > FrameBits - 1 - nbits; b--) begin
      stamp = stamp + pick_period(payload[b]);
      send_edge(stamp, 1'b0, typed, typed_res);
    end
  endtask

  initial begin : main
    int unsigned phase, k, base_sent;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (FrameRows[r]) begin
      send_frame(FrameRows[r].payload, FrameRows[r].base, FrameRows[r].lead_start,
                 FrameRows[r].nbits, FrameRows[r].typed, FrameRows[r].data_ok,
                 FrameRows[r].alarm);
    end

    base_sent = edges_sent;
    for (phase = 0; phase < Phases; phase++) begin
      s_axis_tvalid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clk_i);
      repeat (SettleCycles) @(posedge clk_i);
      case (phase)
        0: ;
        1: begin
          cfg_write(RegThr, 32'd0);
          cfg_write(RegTempLo, 32'd0);
          cfg_write(RegTempHi, 32'd255);
          cfg_write(RegHumLo, 32'd0);
          cfg_write(RegHumHi, 32'd255);
          for (k = 0; k < 3; k++) cfg_write(NumRegs + k, $urandom);
        end
        2: begin
          cfg_write(RegThr, 32'hFFFF);
          cfg_write(RegTempLo, 32'd255);
          cfg_write(RegTempHi, 32'd0);
          cfg_write(RegHumLo, 32'd255);
          cfg_write(RegHumHi, 32'd0);
        end
        3: begin
          cfg_write(RegThr, 32'd1);
          cfg_write(RegTempLo, ApbDataW'(TempLoReset));
          cfg_write(RegTempHi, ApbDataW'(TempHiReset));
          cfg_write(RegHumLo, ApbDataW'(HumLoReset));
          cfg_write(RegHumHi, ApbDataW'(HumHiReset));
        end
        default: begin
          cfg_write(RegThr, ($urandom & 32'hFFFF_0000) | $urandom_range(1, 400));
          cfg_write(RegTempLo, $urandom);
          cfg_write(RegTempHi, $urandom);
          cfg_write(RegHumLo, $urandom);
          cfg_write(RegHumHi, $urandom);
        end
      endcase
      gap_pct   = GapPct[phase];
      stall_pct = StallPct[phase];
      // long receiver hold-off so the output side fills and the input stalls
      if (phase == 4) begin
        hold_until = cycles + HoldCycles;
        repeat (HoldFrames) send_frame(make_payload(), CaptureW'($urandom), 1'b1, FrameBits,
                                       1'b0, 1'b0, AlarmNone);
      end
      while (edges_sent - base_sent < (phase + 1) * PhaseEdges) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 6)) send_edge(CaptureW'($urandom), 1'($urandom), 1'b0, '0);
          1: send_frame(make_payload(), CaptureW'($urandom), 1'b1, $urandom_range(1, 39),
                        1'b0, 1'b0, AlarmNone);
          default: send_frame(make_payload(), CaptureW'($urandom), $urandom_range(0, 9) != 0,
                              FrameBits, 1'b0, 1'b0, AlarmNone);
        endcase
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
